/* design/brst_pkg.sv */
// Shared types and constants for the bitmap-rank sparse table.
package brst_pkg;

    localparam int TABLE_ENTRIES = 8192;
    localparam int WORD_BITS     = 64;
    localparam int VALUE_BITS    = 8;

    localparam int IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int POS_W     = IDX_W + 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int NUM_WORDS = TABLE_ENTRIES / WORD_BITS;
    localparam int WADDR_W   = $clog2(NUM_WORDS);
    localparam int POP_W     = BIT_W + 1;
    localparam int WRAM_W    = POS_W + WORD_BITS;

    localparam int OP_W     = 2;
    localparam int S_DATA_W = 24;
    localparam int S_USER_W = OP_W;
    localparam int M_DATA_W = VALUE_BITS;
    localparam int M_USER_W = 1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_LOOKUP = 2'd2
    } t_brst_op;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_WORD  = 2'd1,
        S_VALUE = 2'd2
    } t_brst_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic lk_start;
        logic lk_rank;
        logic out_load;
    } t_brst_cmd;

endpackage

/* design/brst_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module brst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/brst_ctrl.sv */
// Controller state machine: item decode, lookup sequencing and output handshake.
module brst_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  brst_pkg::t_brst_op   i_op,
    input  logic                 i_m_tready,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    output brst_pkg::t_brst_cmd  o_cmd
);

    brst_pkg::t_brst_state r_state;
    brst_pkg::t_brst_state n_state;
    logic                  r_out_valid;
    logic                  n_out_valid;
    brst_pkg::t_brst_cmd   cmd;
    logic                  accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brst_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        cmd        = '0;
        o_s_tready = 1'b0;
        accept     = 1'b0;
        unique case (r_state)
            brst_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                accept     = i_s_tvalid;
                if (accept) begin
                    unique case (i_op)
                        brst_pkg::OP_CLEAR:  cmd.clear = 1'b1;
                        brst_pkg::OP_LOAD:   cmd.load  = 1'b1;
                        brst_pkg::OP_LOOKUP: begin
                            cmd.lk_start = 1'b1;
                            n_state      = brst_pkg::S_WORD;
                        end
                        default: ;
                    endcase
                end
            end
            brst_pkg::S_WORD: begin
                cmd.lk_rank = 1'b1;
                n_state     = brst_pkg::S_VALUE;
            end
            brst_pkg::S_VALUE: begin
                if (!r_out_valid || i_m_tready) begin
                    cmd.out_load = 1'b1;
                    n_state      = brst_pkg::S_IDLE;
                end
            end
            default: n_state = brst_pkg::S_IDLE;
        endcase

        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_cmd      = cmd;
    assign o_m_tvalid = r_out_valid;

    // A pending result is never overwritten before it has been taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("brst_ctrl: result overwritten while pending");

    // An accepted lookup passes through the word state into the value state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == brst_pkg::OP_LOOKUP) |=> ##1 (r_state == brst_pkg::S_VALUE))
        else $error("brst_ctrl: lookup sequence broken");

    // No new item is taken while a lookup is in flight.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != brst_pkg::S_IDLE) |-> !o_s_tready)
        else $error("brst_ctrl: item accepted during a lookup");

endmodule

/* design/brst_dp.sv */
// Datapath: load counters, word and value memories, rank computation, result register.
module brst_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  brst_pkg::t_brst_cmd                 i_cmd,
    input  logic [brst_pkg::IDX_W-1:0]          i_lookup_index,
    input  logic [brst_pkg::VALUE_BITS-1:0]     i_entry_value,
    output logic [brst_pkg::VALUE_BITS-1:0]     o_result_value,
    output logic                                o_present
);

    localparam logic [63:0] M1 = 64'h5555555555555555;
    localparam logic [63:0] M2 = 64'h3333333333333333;
    localparam logic [63:0] M4 = 64'h0f0f0f0f0f0f0f0f;

    function automatic logic [brst_pkg::POP_W-1:0] f_popcount(input logic [63:0] w);
        logic [63:0] x;
        x = w - ((w >> 1) & M1);
        x = (x & M2) + ((x >> 2) & M2);
        x = (x + (x >> 4)) & M4;
        x = x + (x >> 8);
        x = x + (x >> 16);
        x = x + (x >> 32);
        return x[brst_pkg::POP_W-1:0];
    endfunction

    // Load side state.
    logic [brst_pkg::POS_W-1:0]      r_load_pos;
    logic [brst_pkg::POS_W-1:0]      r_stored;
    logic [brst_pkg::WORD_BITS-1:0]  r_cur_word;
    logic [brst_pkg::POS_W-1:0]      r_cur_prefix;

    // Lookup side state.
    logic [brst_pkg::BIT_W-1:0]      r_lk_bit;
    logic                            r_lk_valid;
    logic                            r_hit;
    logic                            r_rank_ok;
    logic [brst_pkg::VALUE_BITS-1:0] r_out_value;
    logic                            r_out_present;

    logic                            load_full;
    logic                            load_first;
    logic                            val_nz;
    logic                            load_go;
    logic [brst_pkg::BIT_W-1:0]      load_bit;
    logic [brst_pkg::WORD_BITS-1:0]  n_cur_word;
    logic [brst_pkg::POS_W-1:0]      n_cur_prefix;

    logic [brst_pkg::WRAM_W-1:0]     wram_rdata;
    logic [brst_pkg::WORD_BITS-1:0]  lk_word;
    logic [brst_pkg::WORD_BITS-1:0]  lk_mask;
    logic [brst_pkg::POS_W-1:0]      lk_prefix;
    logic [brst_pkg::POS_W-1:0]      lk_rank;
    logic [brst_pkg::VALUE_BITS-1:0] vram_rdata;

    assign load_full  = r_load_pos[brst_pkg::POS_W-1];
    assign load_bit   = r_load_pos[brst_pkg::BIT_W-1:0];
    assign load_first = (load_bit == '0);
    assign val_nz     = (i_entry_value != '0);
    assign load_go    = i_cmd.load && !load_full;

    always_comb begin
        n_cur_word   = load_first ? '0 : r_cur_word;
        n_cur_word   = n_cur_word
                     | (brst_pkg::WORD_BITS'(val_nz) << load_bit);
        n_cur_prefix = load_first ? r_stored : r_cur_prefix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos <= '0;
            r_stored   <= '0;
        end else if (i_cmd.clear) begin
            r_load_pos <= '0;
            r_stored   <= '0;
        end else if (load_go) begin
            r_load_pos <= r_load_pos + brst_pkg::POS_W'(1);
            r_stored   <= r_stored + brst_pkg::POS_W'(val_nz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_go) begin
            r_cur_word   <= n_cur_word;
            r_cur_prefix <= n_cur_prefix;
        end
    end

    // Word memory: prefix count above the presence word, one row per word.
    brst_ram #(
        .WIDTH (brst_pkg::WRAM_W),
        .DEPTH (brst_pkg::NUM_WORDS)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (load_go),
        .i_waddr (r_load_pos[brst_pkg::IDX_W-1:brst_pkg::BIT_W]),
        .i_wdata ({n_cur_prefix, n_cur_word}),
        .i_re    (i_cmd.lk_start),
        .i_raddr (i_lookup_index[brst_pkg::IDX_W-1:brst_pkg::BIT_W]),
        .o_rdata (wram_rdata)
    );

    // A word row is valid once the load position has entered it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lk_start) begin
            r_lk_bit   <= i_lookup_index[brst_pkg::BIT_W-1:0];
            r_lk_valid <= {1'b0, i_lookup_index[brst_pkg::IDX_W-1:brst_pkg::BIT_W],
                           {brst_pkg::BIT_W{1'b0}}} < r_load_pos;
        end
    end

    always_comb begin
        lk_word   = wram_rdata[brst_pkg::WORD_BITS-1:0]
                  & {brst_pkg::WORD_BITS{r_lk_valid}};
        lk_prefix = wram_rdata[brst_pkg::WRAM_W-1:brst_pkg::WORD_BITS];
        lk_mask   = (brst_pkg::WORD_BITS'(1) << r_lk_bit) - brst_pkg::WORD_BITS'(1);
        lk_rank   = lk_prefix + brst_pkg::POS_W'(f_popcount(lk_word & lk_mask));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lk_rank) begin
            r_hit     <= lk_word[r_lk_bit];
            r_rank_ok <= !lk_rank[brst_pkg::POS_W-1];
        end
    end

    brst_ram #(
        .WIDTH (brst_pkg::VALUE_BITS),
        .DEPTH (brst_pkg::TABLE_ENTRIES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (load_go && val_nz),
        .i_waddr (r_stored[brst_pkg::IDX_W-1:0]),
        .i_wdata (i_entry_value),
        .i_re    (i_cmd.lk_rank),
        .i_raddr (lk_rank[brst_pkg::IDX_W-1:0]),
        .o_rdata (vram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value   <= (r_hit && r_rank_ok) ? vram_rdata : '0;
            r_out_present <= r_hit;
        end
    end

    assign o_result_value = r_out_value;
    assign o_present      = r_out_present;

    // The load position never runs past the end of the table.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_pos <= brst_pkg::POS_W'(brst_pkg::TABLE_ENTRIES))
        else $error("brst_dp: load position beyond table");

    // Packed values can never outnumber the positions loaded.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= r_load_pos)
        else $error("brst_dp: stored count exceeds load position");

    // An absent entry always answers zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (r_out_present || r_out_value == '0))
        else $error("brst_dp: absent entry gave a non-zero value");

endmodule

/* design/bitmap_rank_sparse_table.sv */
// Top level of the bitmap-rank sparse table: stream ports, controller and datapath.
//
// This block holds an 8192-entry byte table in compressed form: a presence
// bitmap of 128 words of 64 bits, a prefix count of set bits for each word,
// and the non-zero bytes packed in ascending position order. Each input beat
// carries an operation in tuser: clear empties the table, load supplies the
// next original entry (a zero byte only advances the position, loads past the
// last position are ignored), and lookup returns one result beat holding the
// stored byte and a presence flag, with zero and a clear flag for an absent
// entry. Clear and load beats can follow one another in every cycle. A lookup
// holds off the next beat while it runs its steps in order: the word memory
// read of bitmap and prefix count, then the value memory read addressed by the
// rank, then the result register load, which waits while a result is still
// pending. The two memory reads are registered and run in sequence. A finished
// result waits in the output register while the next beat is accepted. After
// reset and after a clear the table is empty at once; no clearing pass is run,
// because the load position marks which bitmap words have been written. No
// result is given for clear, load or an unused operation code.
module bitmap_rank_sparse_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // lookup_index [12:0], entry_value [20:13], zero fill [23:21]
    input  logic [brst_pkg::S_DATA_W-1:0] s_axis_tdata,
    // op [1:0]
    input  logic [brst_pkg::S_USER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // result_value [7:0]
    output logic [brst_pkg::M_DATA_W-1:0] m_axis_tdata,
    // present [0]
    output logic [brst_pkg::M_USER_W-1:0] m_axis_tuser
);

    brst_pkg::t_brst_cmd cmd;
    brst_pkg::t_brst_op  op;
    logic                present;

    assign op = brst_pkg::t_brst_op'(s_axis_tuser);

    // The controller sequences each beat and owns both handshakes.
    brst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_op       (op),
        .i_m_tready (m_axis_tready),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_cmd      (cmd)
    );

    // The datapath holds the table, the load counters and the result register.
    brst_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_lookup_index (s_axis_tdata[brst_pkg::IDX_W-1:0]),
        .i_entry_value  (s_axis_tdata[brst_pkg::IDX_W+brst_pkg::VALUE_BITS-1:
                                      brst_pkg::IDX_W]),
        .o_result_value (m_axis_tdata),
        .o_present      (present)
    );

    assign m_axis_tuser = brst_pkg::M_USER_W'(present);

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the bitmap-rank sparse table with a lookup scoreboard.
`timescale 1ns / 1ps

module tb_top;

    import brst_pkg::*;

    // The one operation code that the block must ignore without a result.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Number of random beats to send after the directed part.
    localparam int RANDOM_BEATS = 1250;

    // Cycles without any accepted beat on either side before the run is abandoned.
    // The slowest correct gap is the longest send gap, a lookup and the longest
    // result stall, so this allows many times that.
    localparam int STALL_LIMIT = 1000;

    // Cycles allowed after the last expected result for any stray beat to show.
    localparam int DRAIN_CYCLES = 16;

    // Idling styles: none at all, a full draw from 0 to 16, or mostly none.
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_FULL  = 1;
    localparam int IDLE_BURST = 2;

    // One lookup answer as the block must present it.
    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic                  present;
    } t_lookup_answer;

    // Shadow copy of the compressed table. Every accepted beat is applied to it,
    // and every lookup leaves its answer in a queue for the result side to check.
    class rank_lookup_board;
        logic [WORD_BITS-1:0]  presence_words [NUM_WORDS];
        logic [POS_W-1:0]      word_ranks     [NUM_WORDS];
        logic [VALUE_BITS-1:0] stored_bytes   [TABLE_ENTRIES];
        int unsigned           byte_count;
        int unsigned           next_position;
        t_lookup_answer        answers_due[$];
        int unsigned           faults;

        function new();
            foreach (stored_bytes[i]) begin
                stored_bytes[i] = '0;
            end
            faults = 0;
            empty();
        endfunction

        function void empty();
            foreach (presence_words[w]) begin
                presence_words[w] = '0;
                word_ranks[w]     = '0;
            end
            byte_count    = 0;
            next_position = 0;
        endfunction

        function void flag(string msg);
            faults++;
            if (faults <= 10) begin
                $display("[%0t] %s", $realtime, msg);
            end
        endfunction

        // Applies one accepted input beat to the shadow table.
        function void note_beat(logic [OP_W-1:0] op, logic [IDX_W-1:0] index,
                                logic [VALUE_BITS-1:0] value);
            int unsigned          w;
            int unsigned          b;
            int unsigned          rank;
            logic [WORD_BITS-1:0] lower;
            t_lookup_answer       answer;
            case (op)
                OP_CLEAR: begin
                    empty();
                end
                OP_LOAD: begin
                    if (next_position < TABLE_ENTRIES) begin
                        w = next_position / WORD_BITS;
                        b = next_position % WORD_BITS;
                        // The rank base of a word is fixed when its first bit loads.
                        if (b == 0) begin
                            word_ranks[w] = POS_W'(byte_count);
                        end
                        if (value != '0) begin
                            presence_words[w][b]     = 1'b1;
                            stored_bytes[byte_count] = value;
                            byte_count++;
                        end
                        next_position++;
                    end
                end
                OP_LOOKUP: begin
                    w = index / WORD_BITS;
                    b = index % WORD_BITS;
                    answer.value   = '0;
                    answer.present = 1'b0;
                    if (presence_words[w][b]) begin
                        lower = presence_words[w] & ((64'd1 << b) - 64'd1);
                        rank  = word_ranks[w] + $countones(lower);
                        answer.value   = stored_bytes[rank];
                        answer.present = 1'b1;
                    end
                    answers_due.push_back(answer);
                end
                default: begin
                end
            endcase
        endfunction

        // Compares one accepted result beat with the oldest answer still due.
        function void check_answer(logic [VALUE_BITS-1:0] value, logic present);
            t_lookup_answer answer;
            if (answers_due.size() == 0) begin
                flag($sformatf("result beat with nothing due: value %0d present %0d",
                               value, present));
                return;
            end
            answer = answers_due.pop_front();
            if (value !== answer.value || present !== answer.present) begin
                flag($sformatf({"lookup mismatch: expected value %0d present %0d, ",
                                "got value %0d present %0d"},
                               answer.value, answer.present, value, present));
            end
        endfunction
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // lookup_index [12:0], entry_value [20:13], zero fill [23:21]
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    // op [1:0]
    logic [S_USER_W-1:0] s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // result_value [7:0]
    logic [M_DATA_W-1:0] m_axis_tdata;
    // present [0]
    logic [M_USER_W-1:0] m_axis_tuser;

    rank_lookup_board board = new();

    int          tx_idle_mode = IDLE_NONE;
    int          rx_idle_mode = IDLE_NONE;
    int unsigned quiet_cycles = 0;
    int unsigned random_sent  = 0;

    bitmap_rank_sparse_table u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Draws how many cycles one side waits before its next beat.
    function automatic int unsigned idle_cycles(int mode);
        case (mode)
            IDLE_FULL:  return $urandom_range(0, 16);
            IDLE_BURST: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
            default:    return 0;
        endcase
    endfunction

    // A random table position and a random byte, drawn at the field widths.
    function automatic logic [IDX_W-1:0] any_index();
        return IDX_W'($urandom_range(0, TABLE_ENTRIES - 1));
    endfunction

    function automatic logic [VALUE_BITS-1:0] any_byte(int unsigned lo);
        return VALUE_BITS'($urandom_range(lo, 255));
    endfunction

    // Offers one input beat and waits for it to be taken. The valid stays high
    // afterwards, so that a following beat with no gap goes out back to back.
    task automatic send_beat(logic [OP_W-1:0] op, logic [IDX_W-1:0] index,
                             logic [VALUE_BITS-1:0] value);
        int unsigned gap;
        gap = idle_cycles(tx_idle_mode);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, value, index};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        board.note_beat(op, index, value);
    endtask

    // A lookup that mostly lands in the loaded part of the table, where the
    // rank logic is actually exercised, and otherwise anywhere at all.
    task automatic lookup_somewhere();
        logic [IDX_W-1:0] index;
        if (board.next_position > 0 && $urandom_range(0, 9) < 7) begin
            index = IDX_W'($urandom_range(0, board.next_position - 1));
        end else begin
            index = any_index();
        end
        send_beat(OP_LOOKUP, index, any_byte(0));
    endtask

    // Result side: for every beat it draws a stall, then holds ready until a
    // beat is taken. With no stall drawn, ready simply stays high.
    initial begin
        int unsigned stall;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            stall = idle_cycles(rx_idle_mode);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) begin
                @(posedge i_clk);
            end
        end
    end

    // Every result beat is checked at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_answer(m_axis_tdata, m_axis_tuser[0]);
        end
    end

    // Watchdog: any accepted beat on either side shows that the block is alive.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("bitmap_rank_sparse_table regression: fail");
            $finish;
        end
    end

    initial begin
        int unsigned phase_len;
        int unsigned zero_pct;
        int unsigned pick;
        int unsigned probe_count;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. An empty table must answer absent at both ends, then a
        // few loads with the value extremes and a zero that only moves the
        // position, lookups on and past them, the unused code, and a clear.
        tx_idle_mode = IDLE_FULL;
        rx_idle_mode = IDLE_FULL;
        send_beat(OP_LOOKUP, 13'd0, 8'd0);
        send_beat(OP_LOOKUP, 13'd8191, 8'd255);
        send_beat(OP_UNUSED, 13'd8191, 8'd255);
        send_beat(OP_LOAD, 13'd8191, 8'd255);
        send_beat(OP_LOAD, 13'd0, 8'd0);
        send_beat(OP_LOAD, 13'd0, 8'd1);
        send_beat(OP_LOAD, 13'd0, 8'd128);
        send_beat(OP_UNUSED, 13'd0, 8'd77);
        send_beat(OP_LOOKUP, 13'd0, 8'd0);
        send_beat(OP_LOOKUP, 13'd1, 8'd0);
        send_beat(OP_LOOKUP, 13'd2, 8'd0);
        send_beat(OP_LOOKUP, 13'd3, 8'd0);
        // A position that no load has reached yet, then a word that none has reached.
        send_beat(OP_LOOKUP, 13'd4, 8'd0);
        send_beat(OP_LOOKUP, 13'd64, 8'd0);
        send_beat(OP_CLEAR, 13'd8191, 8'd255);
        send_beat(OP_LOOKUP, 13'd0, 8'd0);
        send_beat(OP_LOAD, 13'd0, 8'd7);
        send_beat(OP_LOOKUP, 13'd0, 8'd0);
        send_beat(OP_LOOKUP, 13'd8191, 8'd0);

        // Random part, in phases. Most phases start from an empty table and load
        // a run of entries with a drawn share of zeros, interleaved with lookups;
        // a few carry on from the previous contents. Stray clears and unused
        // codes are mixed in as noise, and each phase has its own idling style.
        while (random_sent < RANDOM_BEATS) begin
            tx_idle_mode = $urandom_range(IDLE_NONE, IDLE_BURST);
            rx_idle_mode = $urandom_range(IDLE_NONE, IDLE_BURST);
            case ($urandom_range(0, 3))
                0:       zero_pct = 0;
                1:       zero_pct = 100;
                default: zero_pct = $urandom_range(0, 100);
            endcase
            if ($urandom_range(0, 4) != 0) begin
                send_beat(OP_CLEAR, any_index(), any_byte(0));
                random_sent++;
            end
            phase_len = $urandom_range(1, 150);
            repeat (phase_len) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    if ($urandom_range(0, 99) < zero_pct) begin
                        send_beat(OP_LOAD, any_index(), 8'd0);
                    end else begin
                        send_beat(OP_LOAD, any_index(), any_byte(1));
                    end
                end else if (pick < 95) begin
                    lookup_somewhere();
                end else if (pick < 98) begin
                    send_beat(OP_UNUSED, any_index(), any_byte(0));
                end else begin
                    send_beat(OP_CLEAR, any_index(), any_byte(0));
                end
                random_sent++;
            end
            probe_count = $urandom_range(5, 20);
            repeat (probe_count) begin
                lookup_somewhere();
                random_sent++;
            end
        end

        // Wind down: stop offering beats, wait for every answer still due, then
        // give the block a little longer in case a stray result beat appears.
        s_axis_tvalid <= 1'b0;
        while (board.answers_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.faults == 0) begin
            $display("bitmap_rank_sparse_table regression: pass");
        end else begin
            $display("bitmap_rank_sparse_table regression: fail");
        end
        $finish;
    end

endmodule
